// ----- rtl/core/bus_frame_field_sequencer_macros.svh -----
// Assertion helpers for the frame sequencer.
// Each expects clk and arst_n in scope.
`ifndef BUS_FRAME_FIELD_SEQUENCER_MACROS_SVH
`define BUS_FRAME_FIELD_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BFFS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled in reset.
`define BFFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- rtl/core/bffs_pkg.sv -----
package bffs_pkg;

	// Frame phase; codes equal the field type reported for that phase.
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_ID1  = 4'd1,
		PH_ID2  = 4'd2,
		PH_INS1 = 4'd3,
		PH_INS2 = 4'd4,
		PH_DATA = 4'd5,
		PH_CRC1 = 4'd6,
		PH_CRC2 = 4'd7,
		PH_ACK  = 4'd8
	} bffs_phase_t;

	localparam logic [3:0] FT_BREAK  = 4'd0;
	localparam logic [3:0] FT_CRC2   = 4'd7;
	localparam logic       OP_BREAK  = 1'b1;
	localparam logic [7:0] ACK_OK    = 8'h7E;
	localparam logic [1:0] VER_1_0   = 2'd0;

	// error_flags bit positions
	localparam int ERR_FRAMING   = 0;
	localparam int ERR_BREAK_EXP = 1;
	localparam int ERR_MISSING   = 2;
	localparam int ERR_ACK       = 3;

	// Configuration register indexes
	localparam int             CFG_IDX_W     = 3;
	localparam logic [2:0]     CFG_VERSION   = 3'd0;
	localparam logic [2:0]     CFG_ACK_EN    = 3'd1;
	localparam logic [2:0]     CFG_ACK_TABLE = 3'd2;
	localparam logic [2:0]     CFG_NODE0     = 3'd3;
	localparam logic [2:0]     CFG_NODE3     = 3'd6;
	localparam int             NODE_WORDS    = 4;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic       framing_error;
	} bffs_in_t;

	typedef struct packed {
		logic [3:0]  field_type;
		logic [7:0]  field_value;
		logic [6:0]  data_index;
		logic [3:0]  error_flags;
		logic        frame_start;
		logic        frame_end;
		logic [1:0]  crc_feed_count;
		logic [7:0]  crc_feed_first;
		logic [7:0]  crc_feed_second;
		logic [15:0] received_crc;
		logic        crc_compare;
	} bffs_out_t;

	typedef struct packed {
		logic [1:0]                   protocol_version;
		logic                         ack_enable;
		logic                         ack_from_table;
		logic [NODE_WORDS-1:0][63:0]  node_ack_bits;
	} bffs_cfg_t;

	typedef struct packed {
		bffs_phase_t phase;
		logic [7:0]  first_id;
		logic [7:0]  second_id;
		logic [7:0]  bytes_left;
		logic        byte_phase;
		logic [7:0]  previous_byte;
		logic [7:0]  crc_first_byte;
		logic        ack_expected;
	} bffs_state_t;

endpackage

// ----- rtl/core/bffs_cfg_regs.sv -----
module bffs_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [bffs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                        cfg_data,
	output bffs_pkg::bffs_cfg_t                cfg
);
	import bffs_pkg::*;

	logic [1:0] node_word;

	assign node_word = 2'(cfg_index - CFG_NODE0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.protocol_version <= 2'd2;
			cfg.ack_enable       <= 1'b0;
			cfg.ack_from_table   <= 1'b0;
			cfg.node_ack_bits    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VERSION:   cfg.protocol_version <= cfg_data[1:0];
				CFG_ACK_EN:    cfg.ack_enable       <= cfg_data[0];
				CFG_ACK_TABLE: cfg.ack_from_table   <= cfg_data[0];
				default: begin
					// node table words; anything past the list is dropped
					if (cfg_index >= CFG_NODE0 && cfg_index <= CFG_NODE3) begin
						cfg.node_ack_bits[node_word] <= cfg_data;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/bffs_step.sv -----
module bffs_step (
	input  bffs_pkg::bffs_cfg_t   cfg,
	input  bffs_pkg::bffs_state_t cur,
	input  bffs_pkg::bffs_in_t    item,
	output bffs_pkg::bffs_state_t nxt,
	output bffs_pkg::bffs_out_t   res
);
	import bffs_pkg::*;

	function automatic logic [2:0] pop6(input logic [5:0] v);
		logic [2:0] c;
		c = '0;
		for (int i = 0; i < 6; i++) begin
			c = c + 3'(v[i]);
		end
		return c;
	endfunction

	// Number of data bytes implied by the two IDs.
	function automatic logic [7:0] data_count(input logic [1:0] ver,
			input logic [7:0] id1, input logic [7:0] id2);
		logic [3:0] np1;
		logic [6:0] np2;
		np1 = {1'b0, id2[5:3]} + 4'd1;
		np2 = {1'b0, id2[7:2]} + 7'd1;
		if (ver[1]) begin
			return id2[1] ? 8'(np1) * 8'd6 : {3'b0, np1, 1'b0};
		end else if (!id1[0]) begin
			return 8'(pop6({3'b0, id2[4:2]})) * 8'd6;
		end else if (ver == VER_1_0) begin
			return 8'(pop6(id2[7:2])) * 8'd6;
		end else begin
			return {np2, 1'b0};
		end
	endfunction

	function automatic logic ack_wanted(input bffs_cfg_t c,
			input logic [7:0] id1, input logic [7:0] id2);
		logic [7:0] addr;
		logic       want;
		addr = c.protocol_version[1] ? id1 : {2'b0, id1[7:2]};
		want = c.ack_from_table ? c.node_ack_bits[addr[7:6]][addr[5:0]] : c.ack_enable;
		// master-to-slave only
		return want && (c.protocol_version[1] ? !id2[0] : !id1[1]);
	endfunction

	logic       is_v2;
	logic       in_frame;
	logic       feed;
	logic [7:0] b;
	logic [7:0] dc_cur;
	logic [7:0] dc_new;

	assign is_v2    = cfg.protocol_version[1];
	assign b        = item.data_byte;
	assign in_frame = (cur.phase != PH_IDLE) && (cur.phase <= PH_ACK);
	assign dc_cur   = data_count(cfg.protocol_version, cur.first_id, cur.second_id);
	assign dc_new   = data_count(cfg.protocol_version, cur.first_id, b);

	always_comb begin
		nxt  = cur;
		res  = '0;
		feed = 1'b0;
		res.error_flags[ERR_FRAMING] = item.framing_error;

		if (item.op == OP_BREAK) begin
			res.field_type               = FT_BREAK;
			res.error_flags[ERR_MISSING] = in_frame;
			res.frame_start              = 1'b1;
			nxt.phase                    = PH_ID1;
			nxt.previous_byte            = '0;
		end else if (!in_frame) begin
			res.field_type                 = FT_BREAK;
			res.field_value                = b;
			res.error_flags[ERR_BREAK_EXP] = 1'b1;
			nxt.previous_byte              = b;
		end else begin
			res.field_type  = cur.phase;
			res.field_value = b;
			case (cur.phase)
				PH_ID1: begin
					nxt.first_id   = b;
					nxt.byte_phase = 1'b0;
					feed           = 1'b1;
					nxt.phase      = PH_ID2;
				end
				PH_ID2: begin
					nxt.second_id    = b;
					nxt.bytes_left   = dc_new;
					nxt.ack_expected = ack_wanted(cfg, cur.first_id, b);
					nxt.byte_phase   = 1'b1;
					feed             = 1'b1;
					if (is_v2 && b[2]) begin
						nxt.phase = PH_INS1;
					end else begin
						nxt.phase = (dc_new == '0) ? PH_CRC1 : PH_DATA;
					end
				end
				PH_INS1: begin
					nxt.byte_phase = 1'b0;
					feed           = 1'b1;
					nxt.phase      = PH_INS2;
				end
				PH_INS2: begin
					nxt.byte_phase = 1'b1;
					feed           = 1'b1;
					nxt.phase      = (cur.bytes_left == '0) ? PH_CRC1 : PH_DATA;
				end
				PH_DATA: begin
					res.data_index = 7'(dc_cur - cur.bytes_left);
					nxt.byte_phase = !cur.byte_phase;
					feed           = 1'b1;
					if (cur.bytes_left <= 8'd1) begin
						nxt.bytes_left = '0;
						nxt.phase      = PH_CRC1;
					end else begin
						nxt.bytes_left = cur.bytes_left - 8'd1;
					end
				end
				PH_CRC1: begin
					nxt.crc_first_byte = b;
					nxt.phase          = PH_CRC2;
				end
				PH_CRC2: begin
					res.received_crc = is_v2 ? {b, cur.crc_first_byte}
					                         : {cur.crc_first_byte, b};
					res.crc_compare  = 1'b1;
					if (cur.ack_expected) begin
						nxt.phase = PH_ACK;
					end else begin
						res.frame_end = 1'b1;
						nxt.phase     = PH_IDLE;
					end
				end
				default: begin
					// ACK byte
					res.error_flags[ERR_ACK] = (b != ACK_OK);
					res.frame_end            = 1'b1;
					nxt.bytes_left           = '0;
					nxt.phase                = PH_IDLE;
				end
			endcase

			if (feed) begin
				if (is_v2) begin
					// pairs go in second byte first
					if (nxt.byte_phase) begin
						res.crc_feed_count  = 2'd2;
						res.crc_feed_first  = b;
						res.crc_feed_second = cur.previous_byte;
					end
				end else begin
					res.crc_feed_count = 2'd1;
					res.crc_feed_first = b;
				end
			end
			nxt.previous_byte = b;
		end
	end

endmodule

// ----- rtl/core/bus_frame_field_sequencer.sv -----
// Bus frame field sequencer.
// in_*  : one request per line event (break or received byte plus its
//         framing-error bit), valid/ready.
// out_* : one result request per event: field type, data index, error
//         flags, frame start/end, CRC feed bytes, received CRC and strobe.
// cfg_* : register writes (index, 64-bit data); always ready, taken at once.
//         Write only while the block holds no pending request (not enforced).
// Path: an accepted request is held in the input register, then passes
//         the sequencing logic into the result register, which drives out_valid.
// Throughput: one event per cycle while out_ready allows; the frame phase and
//         ID state are updated in the same cycle the result register is loaded.
// Reset: phase idle (waiting for a break), state cleared, version 2,
//         ACK expectation off, node table clear.
// Stall: when out_ready is low the result holds; one further event
//         waits in the input register, after which in_ready drops.
`include "bus_frame_field_sequencer_macros.svh"

module bus_frame_field_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  bffs_pkg::bffs_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output bffs_pkg::bffs_out_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bffs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                        cfg_data
);
	import bffs_pkg::*;

	localparam bffs_state_t STATE_RESET = '{phase: PH_IDLE, default: '0};

	bffs_cfg_t   cfg;
	bffs_state_t state_q;
	bffs_state_t state_nxt;
	bffs_in_t    item_s1;
	logic        item_valid_s1;
	bffs_out_t   res;
	bffs_out_t   res_s2;
	logic        res_valid_s2;
	logic        advance;

	// Event moves into the result register when that slot is free or
	// being drained this cycle.
	assign advance   = item_valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready  = !item_valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	bffs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bffs_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			res_valid_s2  <= 1'b0;
			state_q       <= STATE_RESET;
		end else begin
			if (in_ready) begin
				item_valid_s1 <= in_valid;
			end
			if (advance) begin
				res_valid_s2 <= 1'b1;
				state_q      <= state_nxt;
			end else if (out_ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	// A frame-opening result is always the break field.
	`BFFS_ASSERT_IMPL(a_start_is_break, out_valid && out_data.frame_start,
		out_data.field_type == FT_BREAK)
	// The CRC compare strobe only comes with the second CRC byte.
	`BFFS_ASSERT_IMPL(a_cmp_on_crc2, out_valid && out_data.crc_compare,
		out_data.field_type == FT_CRC2)
	// An accepted request always lands in the input register.
	`BFFS_ASSERT_NEXT(a_in_lands, in_valid && in_ready, item_valid_s1)
	// A request that advances always shows up as a result.
	`BFFS_ASSERT_NEXT(a_adv_shows, advance, out_valid)

endmodule

// ----- test/bus_frame_field_sequencer_test.sv -----
module bus_frame_field_sequencer_test;
	import bffs_pkg::*;

	// Byte events carry op low; the package only names the break code.
	localparam logic OP_BYTE = 1'b0;
	// Cycles without any accepted request before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Random frames are redrawn towards this many data bytes or fewer.
	localparam int SHORT_FRAME = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic      in_valid = 1'b0;
	logic      in_ready;
	bffs_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	bffs_out_t out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	// Register copy seen by the field predictor (follows accepted writes)
	// and the setting the frame generator builds its frames against.
	bffs_cfg_t   cfg_m;
	bffs_cfg_t   stim_cfg;
	// Predictor's own copy of the frame sequencing state.
	bffs_state_t seq;

	bffs_out_t expected_fields[$];
	int        mismatches = 0;
	int        events_sent = 0;
	int        results_checked = 0;
	int        idle_cycles = 0;
	int        sender_idle_pct = 0;
	int        receiver_idle_pct = 0;

	bus_frame_field_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Number of data bytes that the two ID bytes announce, by version rule.
	// Version codes with bit 1 set (2 and the spare 3) follow version 2.
	function automatic logic [7:0] data_bytes_for(logic [1:0] ver, logic [7:0] id1,
			logic [7:0] id2);
		int n;
		begin
			if (ver[1]) begin
				n = id2[5:3] + 1;
				n = id2[1] ? n * 6 : n * 2;
			end else if (!id1[0]) begin
				n = $countones(id2 & 8'h1C) * 6;
			end else if (ver == VER_1_0) begin
				n = $countones(id2 & 8'hFC) * 6;
			end else begin
				n = (id2[7:2] + 1) * 2;
			end
			return n[7:0];
		end
	endfunction

	// ACK byte due after the CRC: global enable or node table bit, and only
	// for master-to-slave frames.
	function automatic logic ack_due_for(bffs_cfg_t c, logic [7:0] id1, logic [7:0] id2);
		logic [7:0] node;
		logic       want;
		begin
			node = c.protocol_version[1] ? id1 : {2'b00, id1[7:2]};
			want = c.ack_from_table ? c.node_ack_bits[node[7:6]][node[5:0]] : c.ack_enable;
			if (c.protocol_version[1])
				return want & ~id2[0];
			return want & ~id1[1];
		end
	endfunction

	// Field predictor: one result per event, advancing the frame state.
	function automatic bffs_out_t sequence_event(bffs_in_t ev);
		bffs_out_t  r;
		logic       feed;
		logic       v2;
		logic [7:0] b;
		logic [7:0] pos;
		begin
			r = '0;
			feed = 1'b0;
			v2 = cfg_m.protocol_version[1];
			b = ev.data_byte;
			r.error_flags[ERR_FRAMING] = ev.framing_error;
			if (ev.op == OP_BREAK) begin
				// a break always opens a frame; inside one it flags a lost byte
				if (seq.phase != PH_IDLE)
					r.error_flags[ERR_MISSING] = 1'b1;
				r.frame_start = 1'b1;
				seq.phase = PH_ID1;
				seq.previous_byte = '0;
			end else if (seq.phase == PH_IDLE) begin
				// stray byte while hunting for a break
				r.field_value = b;
				r.error_flags[ERR_BREAK_EXP] = 1'b1;
				seq.previous_byte = b;
			end else begin
				r.field_type = seq.phase;
				r.field_value = b;
				case (seq.phase)
					PH_ID1: begin
						seq.first_id = b;
						seq.byte_phase = 1'b0;
						feed = 1'b1;
						seq.phase = PH_ID2;
					end
					PH_ID2: begin
						seq.second_id = b;
						seq.bytes_left = data_bytes_for(cfg_m.protocol_version,
							seq.first_id, b);
						seq.ack_expected = ack_due_for(cfg_m, seq.first_id, b);
						seq.byte_phase = 1'b1;
						feed = 1'b1;
						if (v2 && b[2])
							seq.phase = PH_INS1;
						else
							seq.phase = (seq.bytes_left == 0) ? PH_CRC1 : PH_DATA;
					end
					PH_INS1: begin
						seq.byte_phase = 1'b0;
						feed = 1'b1;
						seq.phase = PH_INS2;
					end
					PH_INS2: begin
						seq.byte_phase = 1'b1;
						feed = 1'b1;
						seq.phase = (seq.bytes_left == 0) ? PH_CRC1 : PH_DATA;
					end
					PH_DATA: begin
						pos = data_bytes_for(cfg_m.protocol_version, seq.first_id,
							seq.second_id) - seq.bytes_left;
						r.data_index = pos[6:0];
						seq.byte_phase = ~seq.byte_phase;
						feed = 1'b1;
						if (seq.bytes_left <= 1) begin
							seq.bytes_left = '0;
							seq.phase = PH_CRC1;
						end else begin
							seq.bytes_left = seq.bytes_left - 1;
						end
					end
					PH_CRC1: begin
						seq.crc_first_byte = b;
						seq.phase = PH_CRC2;
					end
					PH_CRC2: begin
						// v2 sends the low byte first, v1 the high byte
						r.received_crc = v2 ? {b, seq.crc_first_byte}
							: {seq.crc_first_byte, b};
						r.crc_compare = 1'b1;
						if (seq.ack_expected) begin
							seq.phase = PH_ACK;
						end else begin
							r.frame_end = 1'b1;
							seq.phase = PH_IDLE;
						end
					end
					default: begin
						if (b != ACK_OK)
							r.error_flags[ERR_ACK] = 1'b1;
						r.frame_end = 1'b1;
						seq.bytes_left = '0;
						seq.phase = PH_IDLE;
					end
				endcase
				// v2 feeds whole pairs, newest byte first; v1 feeds each byte
				if (feed) begin
					if (v2) begin
						if (seq.byte_phase) begin
							r.crc_feed_count = 2'd2;
							r.crc_feed_first = b;
							r.crc_feed_second = seq.previous_byte;
						end
					end else begin
						r.crc_feed_count = 2'd1;
						r.crc_feed_first = b;
					end
				end
				seq.previous_byte = b;
			end
			return r;
		end
	endfunction

	function automatic logic random_framing_error();
		return $urandom_range(15) == 0;
	endfunction

	// Predict at the edge where the event request is taken.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_fields.push_back(sequence_event(in_data));
	end

	// Register writes land in the predictor's copy as they are accepted.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VERSION:   cfg_m.protocol_version <= cfg_data[1:0];
				CFG_ACK_EN:    cfg_m.ack_enable <= cfg_data[0];
				CFG_ACK_TABLE: cfg_m.ack_from_table <= cfg_data[0];
				default:       cfg_m.node_ack_bits[2'(cfg_index - CFG_NODE0)] <= cfg_data;
			endcase
		end
	end

	// Receiver back-pressure.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= receiver_idle_pct);

	// Result checker: every accepted result request against the oldest
	// prediction, field by field.
	always @(posedge clk) begin : check_results
		bffs_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_fields.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: type=%0d val=%h", out_data.field_type,
						out_data.field_value);
			end else begin
				want = expected_fields.pop_front();
				if (out_data.field_type !== want.field_type ||
						out_data.field_value !== want.field_value ||
						out_data.data_index !== want.data_index ||
						out_data.error_flags !== want.error_flags ||
						out_data.frame_start !== want.frame_start ||
						out_data.frame_end !== want.frame_end ||
						out_data.crc_feed_count !== want.crc_feed_count ||
						out_data.crc_feed_first !== want.crc_feed_first ||
						out_data.crc_feed_second !== want.crc_feed_second ||
						out_data.received_crc !== want.received_crc ||
						out_data.crc_compare !== want.crc_compare) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"mismatch exp: type=%0d val=%h idx=%0d err=%h st=%b",
							" end=%b fc=%0d f1=%h f2=%h crc=%h cmp=%b"},
							want.field_type, want.field_value, want.data_index,
							want.error_flags, want.frame_start, want.frame_end,
							want.crc_feed_count, want.crc_feed_first,
							want.crc_feed_second, want.received_crc, want.crc_compare);
						$display({"         act: type=%0d val=%h idx=%0d err=%h st=%b",
							" end=%b fc=%0d f1=%h f2=%h crc=%h cmp=%b"},
							out_data.field_type, out_data.field_value, out_data.data_index,
							out_data.error_flags, out_data.frame_start, out_data.frame_end,
							out_data.crc_feed_count, out_data.crc_feed_first,
							out_data.crc_feed_second, out_data.received_crc,
							out_data.crc_compare);
					end
				end
			end
		end
	end

	// Watchdog: any accepted request on any channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// One event request. Valid is only dropped when a gap is taken, so a
	// back-to-back request never sees valid lowered and raised in one step.
	task automatic send_event(input logic op, input logic [7:0] b, input logic fe);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= '{op: op, data_byte: b, framing_error: fe};
		do @(posedge clk); while (!in_ready);
		events_sent++;
	endtask

	// Wait until every sent event has had its result checked, then keep the
	// input idle to catch anything spurious.
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (results_checked < events_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all seven registers back to back; only called with the block idle.
	task automatic apply_config(input bffs_cfg_t c);
		logic [63:0] value;
		stim_cfg = c;
		for (int i = CFG_VERSION; i <= CFG_NODE3; i++) begin
			case (i[CFG_IDX_W-1:0])
				CFG_VERSION:   value = {62'd0, c.protocol_version};
				CFG_ACK_EN:    value = {63'd0, c.ack_enable};
				CFG_ACK_TABLE: value = {63'd0, c.ack_from_table};
				default:       value = c.node_ack_bits[2'(i - CFG_NODE0)];
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= value;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random traffic: mostly complete frames with random IDs and payload,
	// the rest cut-short frames and stray bytes.
	task automatic send_traffic(input int n);
		int         target;
		int         pick;
		logic [7:0] id1;
		logic [7:0] id2;
		target = events_sent + n;
		while (events_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				send_event(OP_BREAK, 8'($urandom), random_framing_error());
				id1 = 8'($urandom);
				// keep most frames short; long data phases stay occasional
				do id2 = 8'($urandom);
				while (data_bytes_for(stim_cfg.protocol_version, id1, id2) > SHORT_FRAME &&
					$urandom_range(3) != 0);
				send_event(OP_BYTE, id1, random_framing_error());
				send_event(OP_BYTE, id2, random_framing_error());
				if (stim_cfg.protocol_version[1] && id2[2])
					repeat (2) send_event(OP_BYTE, 8'($urandom), random_framing_error());
				repeat (data_bytes_for(stim_cfg.protocol_version, id1, id2))
					send_event(OP_BYTE, 8'($urandom), random_framing_error());
				repeat (2) send_event(OP_BYTE, 8'($urandom), random_framing_error());
				if (ack_due_for(stim_cfg, id1, id2))
					send_event(OP_BYTE, ($urandom_range(7) == 0) ? 8'($urandom) : ACK_OK,
						random_framing_error());
			end else if (pick < 90) begin
				// frame cut short; the next break reports the lost bytes
				send_event(OP_BREAK, 8'($urandom), random_framing_error());
				repeat ($urandom_range(1, 5))
					send_event(OP_BYTE, 8'($urandom), random_framing_error());
			end else begin
				repeat ($urandom_range(1, 3))
					send_event(OP_BYTE, 8'($urandom), random_framing_error());
			end
		end
	endtask

	// Stray byte, a version 2 frame with instruction, a break inside a frame
	// and a slave-to-master frame, all at the reset setting.
	task automatic test_directed_fields();
		send_event(OP_BYTE, 8'hFF, 1'b1);
		send_event(OP_BREAK, 8'h00, 1'b1);
		send_event(OP_BYTE, 8'hFF, 1'b0);
		send_event(OP_BYTE, 8'h04, 1'b0);
		send_event(OP_BYTE, 8'h00, 1'b0);
		send_event(OP_BYTE, 8'hFF, 1'b0);
		send_event(OP_BYTE, 8'hA5, 1'b0);
		send_event(OP_BYTE, 8'h5A, 1'b1);
		send_event(OP_BYTE, 8'h34, 1'b0);
		send_event(OP_BYTE, 8'h12, 1'b0);
		send_event(OP_BREAK, 8'hFF, 1'b0);
		send_event(OP_BYTE, 8'h00, 1'b0);
		send_event(OP_BREAK, 8'h00, 1'b0);
		send_event(OP_BYTE, 8'h3C, 1'b0);
		send_event(OP_BYTE, 8'h01, 1'b0);
		send_event(OP_BYTE, 8'h00, 1'b0);
		send_event(OP_BYTE, 8'hFF, 1'b0);
		send_event(OP_BYTE, 8'hCD, 1'b0);
		send_event(OP_BYTE, 8'hAB, 1'b0);
		drain_requests();
	endtask

	// Global ACK expectation with a bad ACK byte.
	task automatic test_ack_check();
		bffs_cfg_t c;
		c = stim_cfg;
		c.ack_enable = 1'b1;
		apply_config(c);
		send_event(OP_BREAK, 8'h00, 1'b0);
		send_event(OP_BYTE, 8'h00, 1'b0);
		send_event(OP_BYTE, 8'h00, 1'b0);
		send_event(OP_BYTE, 8'h11, 1'b0);
		send_event(OP_BYTE, 8'h22, 1'b0);
		send_event(OP_BYTE, 8'h33, 1'b0);
		send_event(OP_BYTE, 8'h44, 1'b0);
		send_event(OP_BYTE, 8'h00, 1'b0);
		drain_requests();
	endtask

	// Four settings per idling phase, one per version code; phase 1 puts
	// the node table at all-ones and all-zeros.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int ph);
		bffs_cfg_t c;
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		for (int k = 0; k < 4; k++) begin
			c.protocol_version = k[1:0];
			c.ack_enable = 1'((k + ph) % 2);
			c.ack_from_table = 1'(((k / 2) + ph) % 2);
			for (int w = 0; w < NODE_WORDS; w++) begin
				if (ph == 1)
					c.node_ack_bits[2'(w)] = (k % 2 == 0) ? '1 : '0;
				else
					c.node_ack_bits[2'(w)] = {$urandom, $urandom};
			end
			drain_requests();
			apply_config(c);
			send_traffic(80);
		end
	endtask

	initial begin
		cfg_m = '0;
		cfg_m.protocol_version = 2'd2;
		stim_cfg = cfg_m;
		seq = '0;
		seq.phase = PH_IDLE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_fields();
		test_ack_check();
		test_random_traffic(25, 86, 0);
		test_random_traffic(86, 25, 1);
		test_random_traffic(0, 0, 2);
		drain_requests();

		mismatches += expected_fields.size();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bffs_pkg.sv
rtl/core/bffs_cfg_regs.sv
rtl/core/bffs_step.sv
rtl/core/bus_frame_field_sequencer.sv
test/bus_frame_field_sequencer_test.sv
